FILE: rtl/usm_pkg.sv
// ----------------------------------------------------------------------------
// usm_pkg
// Shared constants and helpers for the RGB unsharp mask filter.
// ----------------------------------------------------------------------------
package usm_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int MaxRadius  = 3;
  localparam int LineCount  = 8;
  localparam int StoreDepth = LineCount * MaxWidth;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int ColW       = $clog2(MaxWidth);
  localparam int LineW      = $clog2(LineCount);
  localparam int PixW       = 24;

  localparam logic [2:0] RegBoundary = 3'd0;
  localparam logic [2:0] RegRadius   = 3'd1;
  localparam logic [2:0] RegRowW     = 3'd2;
  localparam logic [2:0] RegColW     = 3'd3;
  localparam logic [2:0] RegGGain    = 3'd4;
  localparam logic [2:0] RegLGain    = 3'd5;
  localparam logic [2:0] RegWidth    = 3'd6;
  localparam logic [2:0] RegHeight   = 3'd7;

  typedef struct packed {
    logic        mode;
    logic [1:0]  radius;
    logic [63:0] row_w;
    logic [63:0] col_w;
    logic [15:0] g_gain;
    logic [15:0] l_gain;
  } cfg_t;

  // mirrored / clamped index into 0..n-1
  function automatic logic [11:0] mirror_idx(input logic signed [12:0] i,
                                             input logic signed [3:0] a,
                                             input logic [10:0] n);
    logic signed [13:0] t;
    logic signed [13:0] nm1;
    begin
      nm1 = $signed({3'b000, n}) - 14'sd1;
      t = i + a;
      if (t > nm1) t = i - a;
      else if (t < 0) t = -t;
      if (t < 0) t = 0;
      if (t > nm1) t = nm1;
      mirror_idx = t[11:0];
    end
  endfunction

endpackage

FILE: rtl/usm_ram.sv
// ----------------------------------------------------------------------------
// usm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module usm_ram #(
  parameter int Width = 24,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/usm_core.sv
// ----------------------------------------------------------------------------
// usm_core
// Window sequencer: walks the Gaussian and Laplacian taps of one output pixel
// through the line store read port, accumulates, then applies gains.
// ----------------------------------------------------------------------------
module usm_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  usm_pkg::cfg_t              cfg,
  input  logic [10:0]                lat_w,
  input  logic [10:0]                lat_h,
  input  logic [usm_pkg::ColW-1:0]   row,
  input  logic [usm_pkg::ColW-1:0]   col,
  output logic [usm_pkg::AddrW-1:0]  raddr,
  input  logic [usm_pkg::PixW-1:0]   rdata,
  output logic                       busy,
  output logic                       done,
  output logic [23:0]                result
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StGSat = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state;
  // tap counter: 0..48 gaussian, 49..53 laplacian
  logic [5:0] tap;
  // gaussian window row / column position, 0..6 each
  logic [2:0] ti, tj;
  logic       pend;
  logic       pend_lap;
  logic [2:0] pend_li;
  logic [31:0] pend_w;
  logic       pend_ok;
  logic [47:0] gacc [3];
  logic signed [12:0] lacc [3];
  logic [7:0] gval [3];
  logic [7:0] lval [3];
  logic signed [25:0] prod [3];

  logic signed [3:0] ta, tb;
  logic [2:0] rad;
  logic       in_win;
  logic       ok;
  logic [11:0] rr, cc;
  logic signed [13:0] rz, cz;
  logic [31:0] w;
  logic [15:0] wr, wc;
  logic [2:0] li;

  always_comb begin
    rad = {1'b0, cfg.radius};
    ta = 4'($signed({1'b0, ti})) - 4'sd3;
    tb = 4'($signed({1'b0, tj})) - 4'sd3;
    li = 3'(tap - 6'd49);
    in_win = 1'b1;
    ok = 1'b1;
    rr = 12'(row);
    cc = 12'(col);
    rz = 14'($signed({1'b0, row})) + 14'(ta);
    cz = 14'($signed({1'b0, col})) + 14'(tb);
    wr = 16'(cfg.row_w >> (6'd16 * 6'(ta < 0 ? -ta : ta)));
    wc = 16'(cfg.col_w >> (6'd16 * 6'(tb < 0 ? -tb : tb)));
    w = 32'(wr) * 32'(wc);
    if (tap < 6'd49) begin
      if ((ta < 0 ? -ta : ta) > $signed({1'b0, rad}) ||
          (tb < 0 ? -tb : tb) > $signed({1'b0, rad}))
        in_win = 1'b0;
      if (cfg.mode) begin
        rr = usm_pkg::mirror_idx($signed({3'b000, row}), ta, lat_h);
        cc = usm_pkg::mirror_idx($signed({3'b000, col}), tb, lat_w);
      end else begin
        if (rz < 0 || rz > $signed({3'b000, lat_h}) - 14'sd1 ||
            cz < 0 || cz > $signed({3'b000, lat_w}) - 14'sd1)
          ok = 1'b0;
        rr = rz[11:0];
        cc = cz[11:0];
      end
    end else begin
      unique case (li)
        3'd0: rr = usm_pkg::mirror_idx($signed({3'b000, row}), -4'sd1, lat_h);
        3'd1: rr = usm_pkg::mirror_idx($signed({3'b000, row}), 4'sd1, lat_h);
        3'd2: cc = usm_pkg::mirror_idx($signed({3'b000, col}), -4'sd1, lat_w);
        3'd3: cc = usm_pkg::mirror_idx($signed({3'b000, col}), 4'sd1, lat_w);
        default: ;
      endcase
    end
    raddr = {rr[usm_pkg::LineW-1:0], cc[usm_pkg::ColW-1:0]};
  end

  assign busy = (state != StIdle);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        StIdle: begin
          pend <= 1'b0;
          if (start) begin
            state <= StRead;
            tap <= 6'd0;
            ti  <= 3'd0;
            tj  <= 3'd0;
            for (int k = 0; k < 3; k++) begin
              gacc[k] <= '0;
              lacc[k] <= '0;
            end
          end
        end
        StRead: begin
          // previous tap's data arrives now
          if (pend) begin
            for (int k = 0; k < 3; k++) begin
              if (pend_lap) begin
                if (pend_li == 3'd4)
                  lacc[k] <= lacc[k] - 13'($signed({5'b0, rdata[8*k +: 8]}) * 4);
                else
                  lacc[k] <= lacc[k] + 13'($signed({5'b0, rdata[8*k +: 8]}));
              end else if (pend_ok) begin
                gacc[k] <= gacc[k] + 48'(pend_w * 40'(rdata[8*k +: 8]));
              end
            end
          end
          pend     <= (tap < 6'd54);
          pend_lap <= (tap >= 6'd49);
          pend_li  <= li;
          pend_w   <= w;
          pend_ok  <= in_win && ok;
          if (tap < 6'd48) begin
            if (tj == 3'd6) begin
              tj <= 3'd0;
              ti <= ti + 3'd1;
            end else tj <= tj + 3'd1;
          end
          if (tap == 6'd54) state <= StGSat;
          else tap <= tap + 6'd1;
        end
        StGSat: begin
          for (int k = 0; k < 3; k++) begin
            gval[k] <= (gacc[k][47:32] > 16'd255) ? 8'd255 : gacc[k][39:32];
            if (lacc[k] < 0) lval[k] <= 8'd0;
            else if (lacc[k] > 13'sd63) lval[k] <= 8'd255;
            else lval[k] <= {lacc[k][5:0], 2'b00};
          end
          state <= StMul;
        end
        StMul: begin
          for (int k = 0; k < 3; k++)
            prod[k] <= $signed({2'b0, 24'(gval[k]) * 24'(cfg.g_gain)})
                     - $signed({2'b0, 24'(lval[k]) * 24'(cfg.l_gain)});
          state <= StOut;
        end
        StOut: begin
          for (int k = 0; k < 3; k++) begin
            if (prod[k] < 0) result[8*k +: 8] <= 8'd0;
            else if (prod[k] + 26'sd128 >= 26'sd65536) result[8*k +: 8] <= 8'd255;
            else result[8*k +: 8] <= 8'(26'(prod[k] + 26'sd128) >> 8);
          end
          done  <= 1'b1;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

FILE: rtl/rgb_unsharp_mask_filter.sv
// ----------------------------------------------------------------------------
// rgb_unsharp_mask_filter
// Output: m_axis_tvalid rises once the core has finished the output pixel that a
// transaction causes; the line store read port is walked over 49 Gaussian and
// 5 Laplacian taps per output.
// Flow: such a transaction holds s_axis_tready low until its pixel is
// taken; no new transaction is accepted while that pixel is pending.
// Transactions that produce no pixel are accepted every cycle.
// Reset clears counters and loads default registers; the line store is not
// cleared.
// ----------------------------------------------------------------------------
module rgb_unsharp_mask_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_red, out_green, out_blue
  output logic        m_axis_tlast,   // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  usm_pkg::cfg_t cfg;
  logic [10:0] width_reg, height_reg;
  logic [10:0] lat_w, lat_h;
  logic [1:0]  lat_d;
  logic [usm_pkg::ColW-1:0] in_row, in_col, out_row, out_col;
  logic in_done;
  logic core_busy, core_done, start;
  logic [23:0] core_res;
  logic [usm_pkg::AddrW-1:0] raddr;
  logic [23:0] rdata;
  logic we;
  logic last_pend;
  logic hold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= 1'b0;
      cfg.radius <= 2'd3;
      cfg.row_w  <= 64'd81642944174777899;
      cfg.col_w  <= 64'd81642944174777899;
      cfg.g_gain <= 16'd512;
      cfg.l_gain <= 16'd256;
      width_reg  <= 11'd1024;
      height_reg <= 11'd1024;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        usm_pkg::RegBoundary: cfg.mode   <= cfg_data[0];
        usm_pkg::RegRadius:   cfg.radius <= cfg_data[1:0];
        usm_pkg::RegRowW:     cfg.row_w  <= cfg_data;
        usm_pkg::RegColW:     cfg.col_w  <= cfg_data;
        usm_pkg::RegGGain:    cfg.g_gain <= cfg_data[15:0];
        usm_pkg::RegLGain:    cfg.l_gain <= cfg_data[15:0];
        usm_pkg::RegWidth:    width_reg  <= cfg_data[10:0];
        usm_pkg::RegHeight:   height_reg <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !core_busy && !start && !hold;
  wire acc = s_axis_tvalid && s_axis_tready;
  wire push = acc && !s_axis_tuser;
  wire first = (in_row == '0) && (in_col == '0);

  // geometry for this pixel (latched on first)
  logic [10:0] w_eff, h_eff;
  logic [1:0]  d_eff;
  always_comb begin
    w_eff = lat_w; h_eff = lat_h; d_eff = lat_d;
    if (first) begin
      w_eff = (width_reg < 11'd4) ? 11'd4 :
              (width_reg > 11'(usm_pkg::MaxWidth)) ? 11'(usm_pkg::MaxWidth) : width_reg;
      h_eff = (height_reg < 11'd4) ? 11'd4 :
              (height_reg > 11'(usm_pkg::MaxHeight)) ? 11'(usm_pkg::MaxHeight) : height_reg;
      d_eff = (cfg.radius == 2'd0) ? 2'd1 : cfg.radius;
    end
  end

  wire [20:0] q   = 21'(in_row) * 21'(w_eff) + 21'(in_col);
  wire [20:0] lag = 21'(d_eff) * 21'(w_eff) + 21'(d_eff);
  wire col_wrap = (11'(in_col) + 11'd1 == w_eff);
  wire row_wrap = (11'(in_row) + 11'd1 == h_eff);

  assign we = push;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0; in_col <= '0; out_row <= '0; out_col <= '0;
      in_done <= 1'b0; start <= 1'b0;
      lat_w <= 11'd1024; lat_h <= 11'd1024; lat_d <= 2'd3;
      m_axis_tvalid <= 1'b0;
      hold <= 1'b0;
    end else begin
      start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (push) begin
        if (first) begin
          lat_w <= w_eff; lat_h <= h_eff; lat_d <= d_eff;
          out_row <= '0; out_col <= '0;
        end
        in_col <= col_wrap ? '0 : in_col + 1'b1;
        if (col_wrap) begin
          in_row <= row_wrap ? '0 : in_row + 1'b1;
        end
        in_done <= (first ? 1'b0 : in_done) | (col_wrap && row_wrap);
        if (q >= lag) begin start <= 1'b1; hold <= 1'b1; end
      end else if (acc && in_done) begin
        start <= 1'b1; hold <= 1'b1;
      end
      if (core_done) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= core_res;
        m_axis_tlast  <= last_pend;
        if (last_pend) begin
          out_row <= '0; out_col <= '0; in_done <= 1'b0;
        end else if (11'(out_col) + 11'd1 == lat_w) begin
          out_col <= '0; out_row <= out_row + 1'b1;
        end else out_col <= out_col + 1'b1;
      end
      // input stays closed until the pixel has left the output register
      if (hold && !core_busy && !start && !core_done && !m_axis_tvalid) hold <= 1'b0;
    end
  end

  assign last_pend = (11'(out_row) + 11'd1 == lat_h) && (11'(out_col) + 11'd1 == lat_w);

  usm_ram #(.Width(usm_pkg::PixW), .Depth(usm_pkg::StoreDepth)) u_store (
    .clk(clk), .we(we),
    .waddr({in_row[usm_pkg::LineW-1:0], in_col}),
    .wdata(s_axis_tdata), .raddr(raddr), .rdata(rdata)
  );

  usm_core u_core (
    .clk(clk), .rst(rst), .start(start), .cfg(cfg),
    .lat_w(lat_w), .lat_h(lat_h), .row(out_row), .col(out_col),
    .raddr(raddr), .rdata(rdata), .busy(core_busy), .done(core_done),
    .result(core_res)
  );
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB unsharp mask filter: drives frames of
// pixels and drain requests with random pacing, predicts every sharpened
// pixel and compares each output transaction field by field.
// ----------------------------------------------------------------------------
class usm_scoreboard;
  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit       frame_end;
  } px_t;

  px_t         expected_px[$];
  int          errors;
  bit          mode;
  bit [1:0]    radius;
  bit [63:0]   row_w, col_w;
  bit [15:0]   g_gain, l_gain;
  bit [10:0]   width, height;
  bit [23:0]   store [usm_pkg::StoreDepth];
  int          in_row, in_col, out_row, out_col;
  bit          frame_done;
  int          lat_w, lat_h, lat_d;

  function new();
    mode = 0; radius = 3;
    row_w = 64'd81642944174777899; col_w = 64'd81642944174777899;
    g_gain = 512; l_gain = 256; width = 1024; height = 1024;
    lat_w = 1024; lat_h = 1024; lat_d = 3;
  endfunction

  function void write_reg(logic [2:0] idx, bit [63:0] val);
    case (idx)
      usm_pkg::RegBoundary: mode = val[0];
      usm_pkg::RegRadius:   radius = val[1:0];
      usm_pkg::RegRowW:     row_w = val;
      usm_pkg::RegColW:     col_w = val;
      usm_pkg::RegGGain:    g_gain = val[15:0];
      usm_pkg::RegLGain:    l_gain = val[15:0];
      usm_pkg::RegWidth:    width = val[10:0];
      usm_pkg::RegHeight:   height = val[10:0];
      default: ;
    endcase
  endfunction

  function longint tap(bit [63:0] w, int off);
    if (off < 0) off = -off;
    if (off > 3) return 0;
    return longint'(w[16*off +: 16]);
  endfunction

  function int reflect(int i, int a, int n);
    int t;
    t = i + a;
    if (t > n - 1) t = i - a;
    else if (t < 0) t = -t;
    if (t < 0) t = 0;
    if (t > n - 1) t = n - 1;
    return t;
  endfunction

  function int sample(int r, int c, int ch);
    bit [23:0] p;
    p = store[(r % usm_pkg::LineCount) * usm_pkg::MaxWidth + c];
    return int'(p[8*ch +: 8]);
  endfunction

  function longint blur(int r, int c, int ch);
    longint acc;
    int rr, cc;
    acc = 0;
    for (int a = -int'(radius); a <= int'(radius); a++)
      for (int b = -int'(radius); b <= int'(radius); b++) begin
        if (mode) begin
          rr = reflect(r, a, lat_h);
          cc = reflect(c, b, lat_w);
        end else begin
          rr = r + a;
          cc = c + b;
          if (rr < 0 || rr > lat_h - 1 || cc < 0 || cc > lat_w - 1) continue;
        end
        acc += tap(row_w, a) * tap(col_w, b) * longint'(sample(rr, cc, ch));
      end
    acc = acc >>> 32;
    return (acc > 255) ? 255 : acc;
  endfunction

  function longint edge_strength(int r, int c, int ch);
    int s;
    s = -4 * sample(r, c, ch);
    s += sample(reflect(r, -1, lat_h), c, ch);
    s += sample(reflect(r, 1, lat_h), c, ch);
    s += sample(r, reflect(c, -1, lat_w), ch);
    s += sample(r, reflect(c, 1, lat_w), ch);
    if (s < 0) s = 0;
    s *= 4;
    if (s > 255) s = 255;
    return s;
  endfunction

  function void sharpen_next();
    px_t    p;
    longint v;
    bit [7:0] ch_val [3];
    p.frame_end = (out_row == lat_h - 1) && (out_col == lat_w - 1);
    for (int ch = 0; ch < 3; ch++) begin
      v = blur(out_row, out_col, ch) * longint'(g_gain)
        - edge_strength(out_row, out_col, ch) * longint'(l_gain);
      if (v < 0) v = 0;
      else v = (v + 128) >>> 8;
      if (v > 255) v = 255;
      ch_val[ch] = v[7:0];
    end
    p.red = ch_val[0]; p.green = ch_val[1]; p.blue = ch_val[2];
    expected_px.push_back(p);
    out_col++;
    if (out_col == lat_w) begin
      out_col = 0;
      out_row++;
    end
    if (p.frame_end) begin
      out_row = 0; out_col = 0; frame_done = 0;
    end
  endfunction

  function void note_input(bit drain, bit [23:0] rgb);
    int q, lag;
    if (drain) begin
      if (frame_done) sharpen_next();
      return;
    end
    if (in_row == 0 && in_col == 0) begin
      lat_w = (width < 4) ? 4 : (width > usm_pkg::MaxWidth) ? usm_pkg::MaxWidth : int'(width);
      lat_h = (height < 4) ? 4 :
              (height > usm_pkg::MaxHeight) ? usm_pkg::MaxHeight : int'(height);
      lat_d = (radius < 1) ? 1 : int'(radius);
      out_row = 0; out_col = 0; frame_done = 0;
    end
    store[(in_row % usm_pkg::LineCount) * usm_pkg::MaxWidth + in_col] = rgb;
    q = in_row * lat_w + in_col;
    lag = lat_d * lat_w + lat_d;
    in_col++;
    if (in_col == lat_w) begin
      in_col = 0;
      in_row++;
      if (in_row == lat_h) begin
        in_row = 0;
        frame_done = 1;
      end
    end
    if (q >= lag) sharpen_next();
  endfunction

  task report(string field, int got, int exp_val);
    $display("mismatch on %s: got %0d, expected %0d", field, got, exp_val);
    errors++;
  endtask

  task check_result(bit [23:0] rgb, bit last);
    px_t p;
    if (expected_px.size() == 0) begin
      report("unexpected pixel", rgb, 0);
      return;
    end
    p = expected_px.pop_front();
    if (rgb[7:0] != p.red)     report("out_red", rgb[7:0], p.red);
    if (rgb[15:8] != p.green)  report("out_green", rgb[15:8], p.green);
    if (rgb[23:16] != p.blue)  report("out_blue", rgb[23:16], p.blue);
    if (last != p.frame_end)   report("frame_end", last, p.frame_end);
  endtask
endclass

module tb_top;
  localparam int CycleLimit = 3000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  usm_scoreboard sb = new();
  int  cycles;
  int  items;
  bit  no_gaps;   // stretches with back-to-back traffic on both sides

  rgb_unsharp_mask_filter u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output side: random backpressure
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  task send(bit drain, bit [23:0] rgb);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= drain;
    s_axis_tdata  <= rgb;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(drain, rgb);
    items++;
  endtask

  task settle();
    s_axis_tvalid <= 0;
    while (sb.expected_px.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task write_reg(logic [2:0] idx, bit [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function bit [7:0] chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function bit [23:0] pixel();
    return {chan(), chan(), chan()};
  endfunction

  // one frame; drains < lag leaves outputs unsent, the next push starts anew
  task run_frame(int w, int h, int drains);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 40) == 0) send(1, pixel());   // premature drain
      send(0, pixel());
    end
    for (int i = 0; i < drains; i++) send(1, pixel());
  endtask

  task random_setup(output int w, output int h, output int d);
    bit [10:0] rw, rh;
    bit [1:0]  rr;
    rw = 11'($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : $urandom_range(4, 12));
    rh = 11'($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : $urandom_range(4, 10));
    rr = 2'($urandom_range(0, 3));
    write_reg(usm_pkg::RegBoundary, 64'($urandom_range(0, 1)));
    write_reg(usm_pkg::RegRadius, 64'(rr));
    case ($urandom_range(0, 3))
      0: begin
        write_reg(usm_pkg::RegRowW, '1);
        write_reg(usm_pkg::RegColW, '1);
      end
      1: begin
        write_reg(usm_pkg::RegRowW, '0);
        write_reg(usm_pkg::RegColW, {$urandom, $urandom});
      end
      default: begin
        // roughly normalized small weights
        write_reg(usm_pkg::RegRowW,
                  {16'($urandom_range(0, 8000)), 16'($urandom_range(0, 12000)),
                   16'($urandom_range(0, 20000)), 16'($urandom_range(10000, 40000))});
        write_reg(usm_pkg::RegColW,
                  {16'($urandom_range(0, 8000)), 16'($urandom_range(0, 12000)),
                   16'($urandom_range(0, 20000)), 16'($urandom_range(10000, 40000))});
      end
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(usm_pkg::RegGGain, 64'hffff);
      1: write_reg(usm_pkg::RegGGain, 64'd0);
      default: write_reg(usm_pkg::RegGGain, 64'($urandom_range(200, 700)));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(usm_pkg::RegLGain, 64'hffff);
      1: write_reg(usm_pkg::RegLGain, 64'd0);
      default: write_reg(usm_pkg::RegLGain, 64'($urandom_range(0, 600)));
    endcase
    write_reg(usm_pkg::RegWidth, 64'(rw));
    write_reg(usm_pkg::RegHeight, 64'(rh));
    w = (rw < 4) ? 4 : int'(rw);
    h = (rh < 4) ? 4 : int'(rh);
    d = (rr < 1) ? 1 : int'(rr);
  endtask

  initial begin
    int w, h, d, lag, drains;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: 4x4 frame, radius 1, mirroring, extreme pixels
    write_reg(usm_pkg::RegBoundary, 64'd1);
    write_reg(usm_pkg::RegRadius, 64'd1);
    write_reg(usm_pkg::RegWidth, 64'd4);
    write_reg(usm_pkg::RegHeight, 64'd4);
    send(1, '0);                                   // drain with nothing pending
    for (int i = 0; i < 16; i++)
      send(0, (i % 3 == 0) ? 24'hffffff : (i % 3 == 1) ? 24'h000000 : 24'hff00ff);
    for (int i = 0; i < 6; i++) send(1, '1);      // last one is ignored
    settle();

    // random frames
    while (items < 1250) begin
      random_setup(w, h, d);
      lag = d * w + d;
      no_gaps = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 7))
        0: drains = $urandom_range(0, lag - 1);
        1: drains = lag + $urandom_range(1, 3);
        default: drains = lag;
      endcase
      run_frame(w, h, drains);
      if ($urandom_range(0, 3) == 0) begin
        // hold off until all output has arrived, then continue
        settle();
      end
      settle();
      no_gaps = 0;
    end

    if (sb.errors == 0 && sb.expected_px.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
